// File: rtl/bdq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded deque with delete by value.
// Used by the cell module and the top level; depends on nothing else.
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int ST_W     = 2;
    localparam int OP_W     = 3;

    localparam logic [FUNC_W-1:0] F_PUSH_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] F_PUSH_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] F_POP_FRONT  = 3'd2;
    localparam logic [FUNC_W-1:0] F_POP_BACK   = 3'd3;
    localparam logic [FUNC_W-1:0] F_REMOVE     = 3'd4;
    localparam logic [FUNC_W-1:0] F_LIST       = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    localparam logic [OP_W-1:0] OP_HOLD       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;
    localparam logic [OP_W-1:0] OP_ROTATE     = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

// File: rtl/bdq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the deque chain: holds one code and its valid bit.
// Depends on bdq_pkg for the command struct and operation codes.
module bdq_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bdq_pkg::t_cell_cmd       i_cmd,
    input  logic [31:0]              i_prev_val,
    input  logic                     i_prev_valid,
    input  logic [31:0]              i_next_val,
    input  logic                     i_next_valid,
    input  logic [31:0]              i_head_val,
    input  logic                     i_seen,
    output logic                     o_seen,
    output logic                     o_take,
    output logic [31:0]              o_val,
    output logic                     o_valid
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;
    logic              r_valid;
    logic              n_valid;
    logic              match;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        o_seen  = i_seen;
        o_take  = 1'b0;
        match   = r_valid && (r_val == i_cmd.value);
        unique case (i_cmd.op)
            OP_PUSH_FRONT: begin
                n_val   = i_prev_val;
                n_valid = i_prev_valid;
            end
            OP_PUSH_BACK: begin
                if (!r_valid && i_prev_valid) begin
                    n_val   = i_cmd.value;
                    n_valid = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                n_val   = i_next_val;
                n_valid = i_next_valid;
            end
            OP_POP_BACK: begin
                if (r_valid && !i_next_valid) begin
                    n_valid = 1'b0;
                    o_take  = 1'b1;
                end
            end
            OP_REMOVE: begin
                o_seen = i_seen || match;
                o_take = match && !i_seen;
                if (i_seen || match) begin
                    n_val   = i_next_val;
                    n_valid = i_next_valid;
                end
            end
            OP_ROTATE: begin
                if (r_valid) begin
                    n_val = i_next_valid ? i_next_val : i_head_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;

endmodule

// File: rtl/bounded_deque_delete_by_value.sv
`timescale 1ns / 1ps
// Top level of the bounded deque with delete by value: a chain of storage cells
// plus command decode and an output register. Depends on bdq_pkg and bdq_cell.
//
// The slave channel takes one command word: tuser is the command code, tdata
// the code to push or the key to remove. The master channel returns result
// words: tdata the code taken out or listed, tuser the status, tlast on the
// final word of a command. Push, pop and remove each give one word in the cycle
// after acceptance; all cells compare and shift in the same cycle, so one such
// command can be accepted every cycle while the receiver takes each word. A list
// command sets a listing flag and, from the cycle after acceptance, walks the chain
// by rotating it one place per cycle while the output register is free, each word
// going out through that register; it holds off the input while it walks, and an
// empty list answers like a pop. No command is accepted until the last word of the
// list has left the cell chain. Command codes six and seven are taken and dropped.
// When the receiver stalls, the output register holds its word and the slave
// side stops accepting while that word is not taken. A synchronous reset
// empties the deque and drops any pending word; stored codes are not cleared.
module bounded_deque_delete_by_value (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic signed [31:0] i_s_tdata,  // [31:0] value
    input  logic [2:0]         i_s_tuser,  // [2:0] func
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic signed [31:0] o_m_tdata,  // [31:0] data
    output logic [1:0]         o_m_tuser,  // [1:0] status
    output logic               o_m_tlast   // last
);
    import bdq_pkg::*;

    t_cell_cmd                cmd;
    logic [DATA_W-1:0]        cell_val   [CAPACITY];
    logic [CAPACITY-1:0]      cell_valid;
    logic [CAPACITY-1:0]      cell_take;
    logic [CAPACITY:0]        seen;
    logic [DATA_W-1:0]        take_data;

    logic [CNT_W-1:0]  r_occ;
    logic [CNT_W-1:0]  n_occ;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_listing;
    logic              n_listing;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;
    logic [ST_W-1:0]   r_ostatus;
    logic              r_olast;

    logic              out_free;
    logic              in_fire;
    logic              is_empty;
    logic              is_full;
    logic              res_valid;
    logic [DATA_W-1:0] res_data;
    logic [ST_W-1:0]   res_status;
    logic              res_last;

    assign seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] prev_val;
        logic              prev_valid;
        logic [DATA_W-1:0] next_val;
        logic              next_valid;

        if (g == 0) begin : g_first
            assign prev_val   = cmd.value;
            assign prev_valid = 1'b1;
        end else begin : g_inner
            assign prev_val   = cell_val[g-1];
            assign prev_valid = cell_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign next_val   = '0;
            assign next_valid = 1'b0;
        end else begin : g_body
            assign next_val   = cell_val[g+1];
            assign next_valid = cell_valid[g+1];
        end

        bdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_prev_val   (prev_val),
            .i_prev_valid (prev_valid),
            .i_next_val   (next_val),
            .i_next_valid (next_valid),
            .i_head_val   (cell_val[0]),
            .i_seen       (seen[g]),
            .o_seen       (seen[g+1]),
            .o_take       (cell_take[g]),
            .o_val        (cell_val[g]),
            .o_valid      (cell_valid[g])
        );
    end

    always_comb begin
        take_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            take_data = take_data | (cell_take[k] ? cell_val[k] : '0);
        end
    end

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = !r_listing && out_free;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign is_empty   = (r_occ == '0);
    assign is_full    = (r_occ == CNT_W'(CAPACITY));

    always_comb begin
        cmd.op     = OP_HOLD;
        cmd.value  = i_s_tdata;
        n_occ      = r_occ;
        n_cnt      = r_cnt;
        n_listing  = r_listing;
        res_valid  = 1'b0;
        res_data   = '0;
        res_status = ST_OK;
        res_last   = 1'b1;
        if (r_listing && out_free) begin
            cmd.op    = OP_ROTATE;
            res_valid = 1'b1;
            res_data  = cell_val[0];
            res_last  = (r_cnt == CNT_W'(1));
            n_cnt     = r_cnt - CNT_W'(1);
            n_listing = (r_cnt != CNT_W'(1));
        end else if (in_fire) begin
            unique case (i_s_tuser)
                F_PUSH_FRONT, F_PUSH_BACK: begin
                    res_valid = 1'b1;
                    if (is_full) begin
                        res_status = ST_FULL;
                    end else begin
                        cmd.op = (i_s_tuser == F_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                        n_occ  = r_occ + CNT_W'(1);
                    end
                end
                F_POP_FRONT, F_POP_BACK: begin
                    res_valid = 1'b1;
                    if (is_empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        cmd.op   = (i_s_tuser == F_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
                        res_data = (i_s_tuser == F_POP_FRONT) ? cell_val[0] : take_data;
                        n_occ    = r_occ - CNT_W'(1);
                    end
                end
                F_REMOVE: begin
                    res_valid = 1'b1;
                    if (is_empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        cmd.op = OP_REMOVE;
                        if (seen[CAPACITY]) begin
                            res_data = take_data;
                            n_occ    = r_occ - CNT_W'(1);
                        end else begin
                            res_status = ST_NOTFOUND;
                        end
                    end
                end
                F_LIST: begin
                    if (is_empty) begin
                        res_valid  = 1'b1;
                        res_status = ST_EMPTY;
                    end else begin
                        n_listing = 1'b1;
                        n_cnt     = r_occ;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_cnt     <= '0;
            r_listing <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_occ     <= n_occ;
            r_cnt     <= n_cnt;
            r_listing <= n_listing;
            if (out_free) begin
                r_ovalid <= res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_odata   <= res_data;
            r_ostatus <= res_status;
            r_olast   <= res_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tlast  = r_olast;

    a_occ_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_valid) == int'(r_occ))
        else $error("Occupancy count disagrees with cell valid bits.");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid + CAPACITY'(1)) & cell_valid) == '0)
        else $error("Valid cells are not packed at the front of the chain.");

    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_listing && out_free && r_cnt == CNT_W'(1) |=> !r_listing && o_m_tvalid && o_m_tlast)
        else $error("List walk did not end with a final word.");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_s_tuser == F_PUSH_BACK && is_full |=> o_m_tvalid && o_m_tuser == ST_FULL)
        else $error("Push into a full deque did not report full.");

endmodule

// File: tb/tb_bounded_deque_delete_by_value.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded deque with delete by value: a directed table,
// then random command streams, every result word checked against the row's own expected
// word or a queue-based model. Depends on bdq_pkg and the bounded_deque_delete_by_value top level.
module tb_bounded_deque_delete_by_value;

    import bdq_pkg::*;

    localparam logic [FUNC_W-1:0] F_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] F_SPARE_7 = 3'd7;

    localparam int RAND_ITEMS  = 420;
    localparam int PHASE_ITEMS = 40;
    localparam int RX_HOLD_CYC = 300;
    localparam int DRAIN_CYC   = 2 * CAPACITY + 8;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int DIR_ROWS    = 25;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [ST_W-1:0]          status;
        logic                     last;
    } t_word;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        logic [4:0]               rep;
        logic                     typed;
        logic signed [DATA_W-1:0] exp_data;
        logic [ST_W-1:0]          exp_status;
    } t_cmd_row;

    // A row with typed set carries its own expected word; the others use the model.
    // Repeated rows push value, value + 1, and so on.
    t_cmd_row dir_tab [0:DIR_ROWS-1] = '{
        '{F_POP_FRONT,  32'sh0000_0000, 5'd1,  1'b1, 32'sh0000_0000, ST_EMPTY},
        '{F_POP_BACK,   32'sh7FFF_FFFF, 5'd1,  1'b1, 32'sh0000_0000, ST_EMPTY},
        '{F_REMOVE,     32'sh0000_0000, 5'd1,  1'b1, 32'sh0000_0000, ST_EMPTY},
        '{F_LIST,       32'sh0000_0000, 5'd1,  1'b1, 32'sh0000_0000, ST_EMPTY},
        '{F_PUSH_FRONT, 32'sh7FFF_FFFF, 5'd1,  1'b1, 32'sh0000_0000, ST_OK},
        '{F_PUSH_BACK,  32'sh8000_0000, 5'd1,  1'b1, 32'sh0000_0000, ST_OK},
        '{F_PUSH_FRONT, 32'shFFFF_FFFF, 5'd1,  1'b1, 32'sh0000_0000, ST_OK},
        '{F_PUSH_BACK,  32'sh8000_0000, 5'd1,  1'b1, 32'sh0000_0000, ST_OK},
        '{F_LIST,       32'sh0000_0000, 5'd1,  1'b0, 32'sh0000_0000, ST_OK},
        '{F_REMOVE,     32'sh0001_2345, 5'd1,  1'b1, 32'sh0000_0000, ST_NOTFOUND},
        '{F_REMOVE,     32'sh8000_0000, 5'd1,  1'b1, 32'sh8000_0000, ST_OK},
        '{F_REMOVE,     32'shFFFF_FFFF, 5'd1,  1'b1, 32'shFFFF_FFFF, ST_OK},
        '{F_LIST,       32'sh0000_0000, 5'd1,  1'b0, 32'sh0000_0000, ST_OK},
        '{F_POP_BACK,   32'sh0000_0000, 5'd1,  1'b1, 32'sh8000_0000, ST_OK},
        '{F_POP_FRONT,  32'sh0000_0000, 5'd1,  1'b1, 32'sh7FFF_FFFF, ST_OK},
        '{F_LIST,       32'sh0000_0000, 5'd1,  1'b1, 32'sh0000_0000, ST_EMPTY},
        '{F_SPARE_6,    32'sh5A5A_5A5A, 5'd1,  1'b0, 32'sh0000_0000, ST_OK},
        '{F_SPARE_7,    32'shA5A5_A5A5, 5'd1,  1'b0, 32'sh0000_0000, ST_OK},
        '{F_PUSH_BACK,  32'sh0000_0000, 5'd16, 1'b1, 32'sh0000_0000, ST_OK},
        '{F_PUSH_FRONT, 32'sh7FFF_FFFF, 5'd1,  1'b1, 32'sh0000_0000, ST_FULL},
        '{F_PUSH_BACK,  32'sh8000_0000, 5'd1,  1'b1, 32'sh0000_0000, ST_FULL},
        '{F_LIST,       32'sh0000_0000, 5'd1,  1'b0, 32'sh0000_0000, ST_OK},
        '{F_REMOVE,     32'sh0000_0005, 5'd1,  1'b1, 32'sh0000_0005, ST_OK},
        '{F_POP_BACK,   32'sh0000_0000, 5'd1,  1'b1, 32'sh0000_000F, ST_OK},
        '{F_PUSH_FRONT, -32'sd7,        5'd1,  1'b1, 32'sh0000_0000, ST_OK}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic signed [31:0] i_s_tdata;   // [31:0] value
    logic [2:0]         i_s_tuser;   // [2:0] func
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic signed [31:0] o_m_tdata;   // [31:0] data
    logic [1:0]         o_m_tuser;   // [1:0] status
    logic               o_m_tlast;

    logic signed [DATA_W-1:0] deque_q [$];
    t_word                    expected_q [$];
    t_word                    step_words [$];

    int err_cnt   = 0;
    int cycle_cnt = 0;
    bit tx_calm   = 1'b0;
    bit rx_hold_req = 1'b0;

    bounded_deque_delete_by_value uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function void deque_step(input logic [FUNC_W-1:0] func,
                             input logic signed [DATA_W-1:0] value);
        int    idx;
        int    hit;
        t_word w;
        step_words.delete();
        w.data   = '0;
        w.status = ST_OK;
        w.last   = 1'b1;
        case (func)
            F_PUSH_FRONT, F_PUSH_BACK: begin
                if (deque_q.size() >= CAPACITY) begin
                    w.status = ST_FULL;
                end else if (func == F_PUSH_FRONT) begin
                    deque_q.push_front(value);
                end else begin
                    deque_q.push_back(value);
                end
                step_words.push_back(w);
            end
            F_POP_FRONT, F_POP_BACK: begin
                if (deque_q.size() == 0) begin
                    w.status = ST_EMPTY;
                end else if (func == F_POP_FRONT) begin
                    w.data = deque_q.pop_front();
                end else begin
                    w.data = deque_q.pop_back();
                end
                step_words.push_back(w);
            end
            F_REMOVE: begin
                hit = -1;
                for (idx = 0; idx < deque_q.size(); idx++) begin
                    if (hit < 0 && deque_q[idx] == value) hit = idx;
                end
                if (deque_q.size() == 0) begin
                    w.status = ST_EMPTY;
                end else if (hit < 0) begin
                    w.status = ST_NOTFOUND;
                end else begin
                    w.data = deque_q[hit];
                    deque_q.delete(hit);
                end
                step_words.push_back(w);
            end
            F_LIST: begin
                if (deque_q.size() == 0) begin
                    w.status = ST_EMPTY;
                    step_words.push_back(w);
                end else begin
                    for (idx = 0; idx < deque_q.size(); idx++) begin
                        w.data = deque_q[idx];
                        w.last = (idx == deque_q.size() - 1);
                        step_words.push_back(w);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_code();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(0, 7) - 32'd4;
            7:          return 32'h7FFF_FFFF;
            8:          return 32'h8000_0000;
            default:    return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    // Bias 0 leans toward pushes, 1 toward pops and removals, 2 is even.
    task automatic pick_cmd(input int bias, output logic [FUNC_W-1:0] func,
                            output logic signed [DATA_W-1:0] value);
        int r;
        int push_pct;
        int idx;
        push_pct = (bias == 0) ? 65 : (bias == 1) ? 20 : 45;
        r = $urandom_range(0, 99);
        value = $urandom;
        if (r < 3) begin
            func = $urandom_range(0, 1) ? F_SPARE_6 : F_SPARE_7;
        end else if (r < 10) begin
            func = F_LIST;
        end else if ($urandom_range(0, 99) < push_pct) begin
            func  = $urandom_range(0, 1) ? F_PUSH_FRONT : F_PUSH_BACK;
            value = pick_code();
        end else begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
                func = F_POP_FRONT;
            end else if (r < 6) begin
                func = F_POP_BACK;
            end else begin
                func = F_REMOVE;
                if (deque_q.size() > 0 && $urandom_range(0, 9) < 6) begin
                    idx   = $urandom_range(0, deque_q.size() - 1);
                    value = deque_q[idx];
                end else begin
                    value = pick_code();
                end
            end
        end
    endtask

    task automatic send_cmd(input logic [FUNC_W-1:0] func,
                            input logic signed [DATA_W-1:0] value,
                            input bit typed, input t_word typed_word);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
        deque_step(func, value);
        if (typed) begin
            expected_q.push_back(typed_word);
        end else begin
            foreach (step_words[i]) expected_q.push_back(step_words[i]);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    initial begin : stim
        int                       row;
        int                       k;
        int                       counted;
        int                       phase;
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] value;
        t_word                    w;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIR_ROWS; row++) begin
            w.data   = dir_tab[row].exp_data;
            w.status = dir_tab[row].exp_status;
            w.last   = 1'b1;
            for (k = 0; k < dir_tab[row].rep; k++) begin
                send_cmd(dir_tab[row].func, dir_tab[row].value + k, dir_tab[row].typed, w);
            end
        end
        wait_drained();

        counted = 0;
        phase   = 0;
        while (counted < RAND_ITEMS) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            if (phase % 4 == 3) begin
                // The receiver stalls for a long stretch while words keep coming.
                wait_drained();
                rx_hold_req = 1'b1;
                tx_calm     = 1'b1;
            end
            for (k = 0; k < PHASE_ITEMS && counted < RAND_ITEMS; k++) begin
                pick_cmd(phase % 3, func, value);
                send_cmd(func, value, 1'b0, '0);
                if (func <= F_LIST) counted++;
            end
            if (phase % 5 == 4) wait_drained();
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : rx_side
        int gap;
        int words;
        bit rx_calm;
        i_m_tready = 1'b0;
        words      = 0;
        rx_calm    = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (RX_HOLD_CYC) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end
            if (words % 48 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            gap = rx_calm ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid && !rx_hold_req);
            words++;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, got data %0d status %0d last %0b",
                         $time, o_m_tdata, o_m_tuser, o_m_tlast);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (o_m_tdata !== want.data) begin
                    $display("%0t: data mismatch: expected %0d, got %0d",
                             $time, want.data, o_m_tdata);
                    err_cnt++;
                end
                if (o_m_tuser !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, o_m_tuser);
                    err_cnt++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.last, o_m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
